// ===== sv/tss_pkg.sv =====
// Shared types and constants for the Taylor series sine block.
// No dependencies; imported by every module of the block.
`default_nettype none
package tss_pkg;

  localparam int PTW   = 16;  // point index and point count width
  localparam int CW    = 5;   // term count width
  localparam int QBITS = 34;  // quotient bits of the angle division
  localparam int DIVW  = QBITS + PTW;  // dividend width (pi * |m|)
  localparam int SW    = 34;  // guard width for the saturating sum

  localparam logic [QBITS-1:0] PI32 = 34'h3243F6A89;  // pi in Q32

  localparam logic signed [SW-1:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [SW-1:0] SAT_LO = -34'sd2147483648;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_TERM_COUNT  = 1'b1;

  typedef struct packed {
    logic          valid;
    logic          neg;   // angle is negative after the fold
    logic          err;   // index out of range
    logic [CW-1:0] cnt;   // terms to sum, already clamped
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [PTW-1:0]   rem;   // partial remainder
    logic [QBITS-1:0] low;   // dividend bits shifting out, quotient shifting in
    logic [PTW-1:0]   n;     // divisor
  } div_t;

endpackage
`default_nettype wire

// ===== sv/tss_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per cycle while en is high.
// Depends on tss_pkg.
`default_nettype none
module tss_div_cell (
  input  wire            clk,
  input  wire            rst,
  input  wire            en,
  input  tss_pkg::div_t  d_in,
  output tss_pkg::div_t  d_out
);
  import tss_pkg::*;

  logic [PTW:0]   trial;
  logic           ge;
  logic [PTW-1:0] rem_next;

  assign trial    = {d_in.rem, d_in.low[QBITS-1]};
  assign ge       = trial >= {1'b0, d_in.n};
  assign rem_next = ge ? PTW'(trial - {1'b0, d_in.n}) : trial[PTW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.ctl <= '0;
    end else if (en) begin
      d_out.ctl <= d_in.ctl;
      d_out.rem <= rem_next;
      d_out.low <= {d_in.low[QBITS-2:0], ge};
      d_out.n   <= d_in.n;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tss_term_cell.sv =====
// One series term cell: adds term TERM to the running sum and derives the
// next term magnitude (times a^2, divided by (2j)(2j+1)). Depends on tss_pkg.
`default_nettype none
module tss_term_cell #(
  parameter int FRAC_BITS = 28,
  parameter int TERM      = 1
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  tss_pkg::ctl_t               ctl_in,
  input  wire [FRAC_BITS+2:0]         mag_in,
  input  wire [FRAC_BITS+3:0]         a2_in,
  input  wire signed [31:0]           acc_in,
  output tss_pkg::ctl_t               ctl_out,
  output logic [FRAC_BITS+2:0]        mag_out,
  output logic [FRAC_BITS+3:0]        a2_out,
  output logic signed [31:0]          acc_out
);
  import tss_pkg::*;

  localparam int MW  = FRAC_BITS + 3;
  localparam int AW  = FRAC_BITS + 4;
  localparam int PW2 = MW + AW;
  localparam int XW  = FRAC_BITS + 6;
  localparam int SH  = XW + 1;
  localparam int RW  = XW - 1;
  localparam int QW  = XW - 2;
  localparam int LW  = XW / 2;
  localparam int HW  = XW - LW;
  localparam longint unsigned DIVC  = (2 * TERM) * (2 * TERM + 1);
  localparam longint unsigned RECIP = (64'd1 << SH) / DIVC;
  localparam logic [XW-1:0]  DIVX  = XW'(DIVC);
  localparam logic [XW-1:0]  HALF  = XW'(DIVC / 2);
  localparam logic [RW-1:0]  RECV  = RW'(RECIP);
  localparam logic [PW2-1:0] RND   = PW2'(64'd1 << (FRAC_BITS - 1));
  localparam logic           EVEN  = ((TERM % 2) == 0);

  // stage 1: accumulate, square step
  logic                  active, tneg;
  logic signed [SW-1:0]  ext_acc, ext_mag, sum_s;
  logic signed [31:0]    acc_sat;
  ctl_t                  ctl1;
  logic signed [31:0]    acc1;
  logic [AW-1:0]         a2_1;
  logic [PW2-1:0]        p1;

  assign active  = ctl_in.cnt >= CW'(TERM);
  assign tneg    = ctl_in.neg ^ EVEN;
  assign ext_acc = SW'(acc_in);
  assign ext_mag = signed'(SW'(mag_in));
  assign sum_s   = tneg ? ext_acc - ext_mag : ext_acc + ext_mag;

  always_comb begin
    if (sum_s > SAT_HI) begin
      acc_sat = 32'sh7fffffff;
    end else if (sum_s < SAT_LO) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = sum_s[31:0];
    end
  end

  // stage 2: round, then reciprocal partial products
  logic [PW2-1:0]     xs;
  logic [XW-1:0]      x2c;
  ctl_t               ctl2;
  logic signed [31:0] acc2;
  logic [AW-1:0]      a2_2;
  logic [XW-1:0]      x2;
  logic [HW+RW-1:0]   ph2;
  logic [LW+RW-1:0]   pl2;

  assign xs  = p1 + RND;
  assign x2c = xs[FRAC_BITS +: XW] + HALF;

  // stage 3: combine partial products into the quotient estimate
  logic [XW+RW-1:0]   tot;
  ctl_t               ctl3;
  logic signed [31:0] acc3;
  logic [AW-1:0]      a2_3;
  logic [XW-1:0]      x3;
  logic [QW-1:0]      qe3;

  assign tot = {ph2, {LW{1'b0}}} + (XW+RW)'(pl2);

  // stage 4: estimate is low by at most one; correct it
  logic [XW-1:0] qd, rem;
  logic [QW-1:0] q;

  assign qd  = XW'(XW'(qe3) * DIVX);
  assign rem = x3 - qd;
  assign q   = (rem >= DIVX) ? qe3 + QW'(1) : qe3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl3    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      ctl_out <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc1    <= active ? acc_sat : acc_in;
      a2_1    <= a2_in;
      p1      <= PW2'(mag_in) * PW2'(a2_in);
      acc2    <= acc1;
      a2_2    <= a2_1;
      x2      <= x2c;
      ph2     <= (HW+RW)'(x2c[XW-1:LW]) * (HW+RW)'(RECV);
      pl2     <= (LW+RW)'(x2c[LW-1:0]) * (LW+RW)'(RECV);
      acc3    <= acc2;
      a2_3    <= a2_2;
      x3      <= x2;
      qe3     <= tot[SH +: QW];
      acc_out <= acc3;
      a2_out  <= a2_3;
      mag_out <= MW'(q);
    end
  end

endmodule
`default_nettype wire

// ===== sv/taylor_sine_of_circle_point.sv =====
// Sine of point i of N around a circle, sin(2*pi*i/N), by a truncated Taylor
// series in signed fixed point with FRAC_BITS fraction bits (Q3.28 default).
// One transaction is taken per cycle while in_ready is high. Each result passes
// through two fold/multiply stages, 34 restoring-division cells for the angle,
// two stages for a and a^2, four stages per term cell and one output register.
// The whole pipeline holds only while a result sits in the output register,
// out_ready is low and the last stage is also full. Out-of-range indices
// return zero with index_error set. Depends on tss_pkg, tss_div_cell and
// tss_term_cell.
`default_nettype none
module taylor_sine_of_circle_point #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 28
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire [15:0]               cfg_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [15:0]               point_index,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [31:0]       sine_value,
  output logic                     index_error
);
  import tss_pkg::*;

  localparam int MW = FRAC_BITS + 3;
  localparam int AW = FRAC_BITS + 4;
  localparam int AMW = FRAC_BITS + 2;
  localparam int TSH = 32 - FRAC_BITS;
  localparam logic [QBITS:0]      TRND = (QBITS+1)'(64'd1 << (31 - FRAC_BITS));
  localparam logic [2*AMW-1:0]    SRND = (2*AMW)'(64'd1 << (FRAC_BITS - 1));

  logic [PTW-1:0] point_count;
  logic [CW-1:0]  term_count;
  logic           adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 16'd64;
      term_count  <= 5'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count <= cfg_data;
        REG_TERM_COUNT:  term_count  <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // fold the angle on integers
  logic [PTW:0]   two_i, diff;
  logic [PTW+1:0] four_i;
  logic           fold, neg_c;
  logic [PTW:0]   um_c;
  logic [CW-1:0]  cnt_c;

  assign two_i  = {point_index, 1'b0};
  assign four_i = {point_index, 2'b00};
  assign fold   = (four_i > {2'b00, point_count}) && (two_i != {1'b0, point_count});
  assign diff   = {1'b0, point_count} - two_i;
  assign neg_c  = fold && (two_i > {1'b0, point_count});
  assign um_c   = fold ? (neg_c ? -diff : diff) : two_i;
  assign cnt_c  = (term_count > CW'(MAX_TERMS)) ? CW'(MAX_TERMS) : term_count;

  ctl_t           a_ctl;
  logic [PTW-1:0] a_um, a_n;
  div_t           b_div;
  logic [DIVW-1:0] prod;

  assign prod = DIVW'(PI32) * DIVW'(a_um);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl     <= '0;
      b_div.ctl <= '0;
    end else if (adv) begin
      a_ctl.valid <= in_valid;
      a_ctl.neg   <= neg_c;
      a_ctl.err   <= point_index >= point_count;
      a_ctl.cnt   <= cnt_c;
      b_div.ctl   <= a_ctl;
      b_div.rem   <= prod[DIVW-1:QBITS];
      b_div.low   <= prod[QBITS-1:0];
      b_div.n     <= a_n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_um <= um_c[PTW-1:0];
      a_n  <= point_count;
    end
  end

  // t = PI32 * |m| / N, one quotient bit per cell
  div_t dv [0:QBITS];
  assign dv[0] = b_div;

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    tss_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .d_in (dv[k]),
      .d_out(dv[k+1])
    );
  end

  // |a| and a^2
  logic [QBITS:0]    tsum;
  logic [2*AMW-1:0]  sq;
  ctl_t              c_ctl, d_ctl;
  logic [AMW-1:0]    c_amag;
  logic [MW-1:0]     d_mag;
  logic [AW-1:0]     d_a2;

  assign tsum = (QBITS+1)'(dv[QBITS].low) + TRND;
  assign sq   = (2*AMW)'(c_amag) * (2*AMW)'(c_amag) + SRND;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
      d_ctl <= '0;
    end else if (adv) begin
      c_ctl <= dv[QBITS].ctl;
      d_ctl <= c_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_amag <= tsum[TSH +: AMW];
      d_mag  <= MW'(c_amag);
      d_a2   <= sq[FRAC_BITS +: AW];
    end
  end

  // series terms
  ctl_t               tc  [0:MAX_TERMS];
  logic [MW-1:0]      mg  [0:MAX_TERMS];
  logic [AW-1:0]      sqa [0:MAX_TERMS];
  logic signed [31:0] acc [0:MAX_TERMS];

  assign tc[0]  = d_ctl;
  assign mg[0]  = d_mag;
  assign sqa[0] = d_a2;
  assign acc[0] = '0;

  for (genvar j = 0; j < MAX_TERMS; j++) begin : g_term
    tss_term_cell #(
      .FRAC_BITS(FRAC_BITS),
      .TERM     (j + 1)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .ctl_in (tc[j]),
      .mag_in (mg[j]),
      .a2_in  (sqa[j]),
      .acc_in (acc[j]),
      .ctl_out(tc[j+1]),
      .mag_out(mg[j+1]),
      .a2_out (sqa[j+1]),
      .acc_out(acc[j+1])
    );
  end

  // hold the pipeline only when the output register and last stage are both full and out_ready is low
  assign adv      = !(tc[MAX_TERMS].valid && out_valid && !out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && tc[MAX_TERMS].valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tc[MAX_TERMS].valid) begin
      sine_value  <= tc[MAX_TERMS].err ? 32'sd0 : acc[MAX_TERMS];
      index_error <= tc[MAX_TERMS].err;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> sine_value == 32'sd0)
    else $error("index error result carries a nonzero value");

  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output can drain");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> out_valid)
    else $error("pending result lost during stall");
`endif

endmodule
`default_nettype wire
